// File: hw/rtl/mpfla_pkg.sv
// shared types and codes for the multi-pool free-list allocator
// beat structs, request and status codes, controller/datapath command and status
// no dependencies
package mpfla_pkg;

  // default sizing
  localparam int unsigned NUM_POOLS_DEF   = 6;
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // fixed beat field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned POOL_W     = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ENTRY_W    = 6;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request codes
  localparam req_t REQ_ALLOC     = REQ_W'(0);
  localparam req_t REQ_REINIT    = REQ_W'(1);
  localparam req_t REQ_CLEAR     = REQ_W'(2);
  localparam req_t REQ_WALK      = REQ_W'(3);
  localparam req_t REQ_WALK_NEXT = REQ_W'(4);

  // result status codes
  localparam status_t ST_OK        = STATUS_W'(0);
  localparam status_t ST_EXHAUSTED = STATUS_W'(1);
  localparam status_t ST_WALK_DONE = STATUS_W'(2);
  localparam status_t ST_NO_WALK   = STATUS_W'(3);

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POOL_W-1:0] pool_id;
    logic              keep_current;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_index;
    logic                active_empty;
  } out_beat_t;

  // datapath operations
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE           = 4'd0;
  localparam dp_op_t OP_FILL           = 4'd1;
  localparam dp_op_t OP_FILL_NEXT_POOL = 4'd2;
  localparam dp_op_t OP_FILL_REBUILD   = 4'd3;
  localparam dp_op_t OP_ALLOC          = 4'd4;
  localparam dp_op_t OP_CLR_STEP       = 4'd5;
  localparam dp_op_t OP_CLR_END        = 4'd6;
  localparam dp_op_t OP_WSTART         = 4'd7;
  localparam dp_op_t OP_KEEP           = 4'd8;
  localparam dp_op_t OP_UNLINK         = 4'd9;
  localparam dp_op_t OP_FREE_CUR       = 4'd10;

  // link read address source
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_FREE   = 2'd0;
  localparam rd_sel_t RD_CURSOR = 2'd1;
  localparam rd_sel_t RD_ACTIVE = 2'd2;

  // result entry source
  typedef logic [1:0] ent_sel_t;
  localparam ent_sel_t ENT_ZERO   = 2'd0;
  localparam ent_sel_t ENT_FREE   = 2'd1;
  localparam ent_sel_t ENT_ACTIVE = 2'd2;
  localparam ent_sel_t ENT_RDATA  = 2'd3;

  typedef struct packed {
    logic     load_req;
    logic     rd_en;
    rd_sel_t  rd_sel;
    dp_op_t   op;
    logic     end_walk;
    logic     fill_full;
    logic     out_load;
    status_t  out_status;
    ent_sel_t ent_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_pool_ok;
    logic pool_ok;
    req_t req;
    logic keep;
    logic fh_nil;
    logic ah_nil;
    logic wc_nil;
    logic rd_nil;
    logic running;
    logic fill_last;
    logic pool_last;
    logic clr_done;
    logic out_valid;
  } ctl_stat_t;

endpackage

// File: hw/rtl/mpfla_dpath.sv
// datapath of the multi-pool free-list allocator: link memory, per-pool heads,
// walk state, entry-count registers and the result register
// depends on mpfla_pkg
module mpfla_dpath import mpfla_pkg::*; #(
  parameter int unsigned NUM_POOLS   = NUM_POOLS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_beat_t              in_beat_i,
  input  ctl_cmd_t              cmd_i,
  output ctl_stat_t             stat_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned DEPTH = NUM_POOLS * MAX_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

  typedef logic [LW-1:0] link_t;

  localparam link_t NIL = LW'(MAX_ENTRIES);

  function automatic logic is_nil(link_t v);
    return v >= NIL;
  endfunction

  function automatic link_t norm(link_t v);
    return (v >= NIL) ? NIL : v;
  endfunction

  // request latch and sweep counter
  req_t              req_q;
  logic              keep_q;
  logic [POOL_W-1:0] pool_q, pool_d;
  link_t             cnt_q, cnt_d;

  // per-pool state
  link_t                fh_q [NUM_POOLS];
  link_t                ah_q [NUM_POOLS];
  link_t                wc_q [NUM_POOLS];
  link_t                wp_q [NUM_POOLS];
  logic [NUM_POOLS-1:0] wr_q;
  logic [CW-1:0]        cfg_q [NUM_POOLS];

  // link memory
  link_t          link_mem [DEPTH];
  link_t          rdata_q;
  logic           mem_we;
  link_t          mem_went, mem_wdata, rd_ent;
  logic [AW-1:0]  row_base, waddr, raddr;

  // result register
  logic      out_valid_q;
  out_beat_t out_q;

  logic [POOL_W-1:0] sel_pool;
  logic              sel_ok, pool_ok, in_pool_ok;
  logic [PW-1:0]     sel_idx;
  link_t             fh_c, ah_c, wc_c, wp_c, n_use, rd_n, ent_v;
  logic              wr_c, fill_last;
  logic [CW-1:0]     cfg_c;
  link_t             fh_n, ah_n, wc_n, wp_n;
  logic              wr_n;

  // one pool select serves the whole cycle: incoming pool on accept, latched otherwise
  assign sel_pool   = cmd_i.load_req ? in_beat_i.pool_id : pool_q;
  assign sel_ok     = {1'b0, sel_pool} < (POOL_W+1)'(NUM_POOLS);
  assign pool_ok    = {1'b0, pool_q} < (POOL_W+1)'(NUM_POOLS);
  assign in_pool_ok = {1'b0, in_beat_i.pool_id} < (POOL_W+1)'(NUM_POOLS);
  assign sel_idx    = sel_ok ? sel_pool[PW-1:0] : '0;

  assign fh_c  = fh_q[sel_idx];
  assign ah_c  = ah_q[sel_idx];
  assign wc_c  = wc_q[sel_idx];
  assign wp_c  = wp_q[sel_idx];
  assign wr_c  = wr_q[sel_idx];
  assign cfg_c = cfg_q[sel_idx];
  assign rd_n  = norm(rdata_q);

  // entry count with out-of-range values clamped
  always_comb begin
    if (cmd_i.fill_full) begin
      n_use = NIL;
    end else if (cfg_c == '0) begin
      n_use = LW'(1);
    end else if (cfg_c > CW'(MAX_ENTRIES)) begin
      n_use = NIL;
    end else begin
      n_use = LW'(cfg_c);
    end
  end

  assign fill_last = cnt_q == (n_use - LW'(1));

  // next per-pool state and link write
  always_comb begin
    fh_n      = fh_c;
    ah_n      = ah_c;
    wc_n      = wc_c;
    wp_n      = wp_c;
    wr_n      = wr_c;
    mem_we    = 1'b0;
    mem_went  = fh_c;
    mem_wdata = NIL;
    cnt_d     = cnt_q;
    pool_d    = pool_q;
    case (cmd_i.op)
      OP_FILL, OP_FILL_NEXT_POOL, OP_FILL_REBUILD: begin
        mem_we    = 1'b1;
        mem_went  = cnt_q;
        mem_wdata = fill_last ? NIL : cnt_q + LW'(1);
        cnt_d     = cnt_q + LW'(1);
        if (cmd_i.op == OP_FILL_NEXT_POOL) begin
          pool_d = pool_q + POOL_W'(1);
          cnt_d  = '0;
        end
        if (cmd_i.op == OP_FILL_REBUILD) begin
          fh_n = '0;
          ah_n = NIL;
          wc_n = NIL;
          wp_n = NIL;
          wr_n = 1'b0;
        end
      end
      OP_ALLOC: begin
        mem_we    = 1'b1;
        mem_went  = fh_c;
        mem_wdata = norm(ah_c);
        fh_n      = rd_n;
        ah_n      = fh_c;
        if (wr_c && is_nil(wp_c)) begin
          wp_n = fh_c;
        end
      end
      OP_CLR_STEP: begin
        mem_we    = 1'b1;
        mem_went  = ah_c;
        mem_wdata = norm(fh_c);
        fh_n      = ah_c;
        ah_n      = rd_n;
        cnt_d     = cnt_q + LW'(1);
      end
      OP_CLR_END: begin
        ah_n = NIL;
        wc_n = NIL;
        wp_n = NIL;
        wr_n = 1'b0;
      end
      OP_WSTART: begin
        wc_n = norm(ah_c);
        wp_n = NIL;
        wr_n = 1'b1;
      end
      OP_KEEP: begin
        wp_n = wc_c;
        wc_n = rd_n;
      end
      OP_UNLINK: begin
        // predecessor takes the successor, or the head does
        if (is_nil(wp_c)) begin
          ah_n = rd_n;
        end else begin
          mem_we    = 1'b1;
          mem_went  = wp_c;
          mem_wdata = rd_n;
        end
      end
      OP_FREE_CUR: begin
        mem_we    = 1'b1;
        mem_went  = wc_c;
        mem_wdata = norm(fh_c);
        fh_n      = wc_c;
        wc_n      = rd_n;
      end
      default: begin
      end
    endcase
    if (cmd_i.end_walk) begin
      wr_n = 1'b0;
      wc_n = NIL;
      wp_n = NIL;
    end
    if (cmd_i.load_req) begin
      pool_d = in_beat_i.pool_id;
      cnt_d  = '0;
    end
  end

  // link read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_FREE:   rd_ent = fh_c;
      RD_CURSOR: rd_ent = wc_c;
      RD_ACTIVE: rd_ent = ah_c;
      default:   rd_ent = fh_c;
    endcase
    if (is_nil(rd_ent)) begin
      rd_ent = '0;
    end
  end

  assign row_base = AW'(sel_idx) * AW'(MAX_ENTRIES);
  assign waddr    = row_base + AW'(mem_went);
  assign raddr    = row_base + AW'(rd_ent);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= link_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= REQ_ALLOC;
      keep_q <= 1'b0;
      pool_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.load_req) begin
        req_q  <= in_beat_i.req_type;
        keep_q <= in_beat_i.keep_current;
      end
      pool_q <= pool_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        fh_q[p] <= '0;
        ah_q[p] <= NIL;
        wc_q[p] <= NIL;
        wp_q[p] <= NIL;
      end
      wr_q <= '0;
    end else if (!cmd_i.load_req && pool_ok) begin
      fh_q[sel_idx] <= fh_n;
      ah_q[sel_idx] <= ah_n;
      wc_q[sel_idx] <= wc_n;
      wp_q[sel_idx] <= wp_n;
      wr_q[sel_idx] <= wr_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        cfg_q[p] <= CW'(MAX_ENTRIES);
      end
    end else if (cfg_we_i && ({1'b0, cfg_idx_i} < (CFG_IDX_W+1)'(NUM_POOLS))) begin
      cfg_q[cfg_idx_i[PW-1:0]] <= CW'(cfg_data_i);
    end
  end

  // result register
  always_comb begin
    case (cmd_i.ent_sel)
      ENT_ZERO:   ent_v = '0;
      ENT_FREE:   ent_v = fh_c;
      ENT_ACTIVE: ent_v = ah_c;
      ENT_RDATA:  ent_v = rd_n;
      default:    ent_v = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.out_status;
      out_q.entry_index  <= ENTRY_W'(ent_v);
      out_q.active_empty <= pool_ok ? is_nil(ah_n) : 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  assign stat_o.in_pool_ok = in_pool_ok;
  assign stat_o.pool_ok    = pool_ok;
  assign stat_o.req        = req_q;
  assign stat_o.keep       = keep_q;
  assign stat_o.fh_nil     = is_nil(fh_c);
  assign stat_o.ah_nil     = is_nil(ah_c);
  assign stat_o.wc_nil     = is_nil(wc_c);
  assign stat_o.rd_nil     = is_nil(rd_n);
  assign stat_o.running    = wr_c;
  assign stat_o.fill_last  = fill_last;
  assign stat_o.pool_last  = pool_q == POOL_W'(NUM_POOLS - 1);
  assign stat_o.clr_done   = is_nil(ah_c) || (cnt_q == NIL);
  assign stat_o.out_valid  = out_valid_q;

endmodule

// File: hw/rtl/mpfla_ctrl.sv
// controller state machine of the multi-pool free-list allocator
// sequences each request into datapath commands; depends on mpfla_pkg
module mpfla_ctrl import mpfla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  req_t      in_req_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  input  ctl_stat_t stat_i,
  output ctl_cmd_t  cmd_o
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MISC   = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_CLR_RD = 4'd5;
  localparam logic [3:0] S_CLR_WR = 4'd6;
  localparam logic [3:0] S_WSTART = 4'd7;
  localparam logic [3:0] S_WNEXT  = 4'd8;
  localparam logic [3:0] S_WREL   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  // take a beat only when idle and the result register is free by the next edge
  assign in_stall_o = (state_q != S_IDLE) || (stat_i.out_valid && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.fill_full = 1'b1;
        cmd_o.op        = OP_FILL;
        if (stat_i.fill_last) begin
          if (stat_i.pool_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_FILL_NEXT_POOL;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = (in_req_i == REQ_ALLOC) ? RD_FREE : RD_CURSOR;
          if (!stat_i.in_pool_ok) begin
            state_d = S_MISC;
          end else begin
            case (in_req_i)
              REQ_ALLOC:     state_d = S_ALLOC;
              REQ_REINIT:    state_d = S_FILL;
              REQ_CLEAR:     state_d = S_CLR_RD;
              REQ_WALK:      state_d = S_WSTART;
              REQ_WALK_NEXT: state_d = S_WNEXT;
              default:       state_d = S_MISC;
            endcase
          end
        end
      end
      S_MISC: begin
        cmd_o.out_load = 1'b1;
        cmd_o.ent_sel  = ENT_ZERO;
        if (!stat_i.pool_ok) begin
          case (stat_i.req)
            REQ_ALLOC:     cmd_o.out_status = ST_EXHAUSTED;
            REQ_WALK:      cmd_o.out_status = ST_WALK_DONE;
            REQ_WALK_NEXT: cmd_o.out_status = ST_NO_WALK;
            default:       cmd_o.out_status = ST_OK;
          endcase
        end else begin
          cmd_o.out_status = ST_OK;
        end
        state_d = S_IDLE;
      end
      S_ALLOC: begin
        cmd_o.out_load = 1'b1;
        if (stat_i.fh_nil) begin
          cmd_o.out_status = ST_EXHAUSTED;
          cmd_o.ent_sel    = ENT_ZERO;
        end else begin
          cmd_o.op         = OP_ALLOC;
          cmd_o.out_status = ST_OK;
          cmd_o.ent_sel    = ENT_FREE;
        end
        state_d = S_IDLE;
      end
      S_FILL: begin
        cmd_o.op = OP_FILL;
        if (stat_i.fill_last) begin
          cmd_o.op         = OP_FILL_REBUILD;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_OK;
          cmd_o.ent_sel    = ENT_ZERO;
          state_d          = S_IDLE;
        end
      end
      S_CLR_RD: begin
        if (stat_i.clr_done) begin
          cmd_o.op         = OP_CLR_END;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_OK;
          cmd_o.ent_sel    = ENT_ZERO;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ACTIVE;
          state_d      = S_CLR_WR;
        end
      end
      S_CLR_WR: begin
        cmd_o.op = OP_CLR_STEP;
        state_d  = S_CLR_RD;
      end
      S_WSTART: begin
        cmd_o.op       = OP_WSTART;
        cmd_o.out_load = 1'b1;
        if (stat_i.ah_nil) begin
          cmd_o.end_walk   = 1'b1;
          cmd_o.out_status = ST_WALK_DONE;
          cmd_o.ent_sel    = ENT_ZERO;
        end else begin
          cmd_o.out_status = ST_OK;
          cmd_o.ent_sel    = ENT_ACTIVE;
        end
        state_d = S_IDLE;
      end
      S_WNEXT: begin
        state_d = S_IDLE;
        if (!stat_i.running) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_NO_WALK;
          cmd_o.ent_sel    = ENT_ZERO;
        end else if (stat_i.wc_nil) begin
          cmd_o.end_walk   = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = ST_WALK_DONE;
          cmd_o.ent_sel    = ENT_ZERO;
        end else if (stat_i.keep) begin
          cmd_o.op       = OP_KEEP;
          cmd_o.out_load = 1'b1;
          if (stat_i.rd_nil) begin
            cmd_o.end_walk   = 1'b1;
            cmd_o.out_status = ST_WALK_DONE;
            cmd_o.ent_sel    = ENT_ZERO;
          end else begin
            cmd_o.out_status = ST_OK;
            cmd_o.ent_sel    = ENT_RDATA;
          end
        end else begin
          cmd_o.op = OP_UNLINK;
          state_d  = S_WREL;
        end
      end
      S_WREL: begin
        cmd_o.op       = OP_FREE_CUR;
        cmd_o.out_load = 1'b1;
        if (stat_i.rd_nil) begin
          cmd_o.end_walk   = 1'b1;
          cmd_o.out_status = ST_WALK_DONE;
          cmd_o.ent_sel    = ENT_ZERO;
        end else begin
          cmd_o.out_status = ST_OK;
          cmd_o.ent_sel    = ENT_RDATA;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/multi_pool_free_list_allocator.sv
// top level of the multi-pool free-list allocator
// joins the controller (mpfla_ctrl) and the datapath (mpfla_dpath); uses mpfla_pkg
//
//   port group    dir   handshake                 beat
//   in_*          in    in_valid_i / in_stall_o   in_beat_t  (req_type, pool_id, keep_current)
//   out_*         out   out_valid_o / out_stall_i out_beat_t (status, entry_index, active_empty)
//   cfg_*         in    cfg_we_i, no wait         cfg_idx_i selects poolN_entries, cfg_data_i
//
// every request latches its beat and starts a registered link read; allocate, walk start,
//   walk next with keep and bad requests then give their result, walk next with release
//   unlinks and then frees the cursor entry; reinit writes one link per entry, clear reads
//   and then writes the link of each active entry; after reset a sweep chains every entry
//   of every pool with in_stall_o high; config writes are taken throughout
// a beat is taken only while idle and with the result register empty or draining
module multi_pool_free_list_allocator import mpfla_pkg::*; #(
  parameter int unsigned NUM_POOLS   = NUM_POOLS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o,
  // entry-count registers
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer: reset sweep, request dispatch, clear loop, walk steps
  mpfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_beat_i.req_type),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // link memory, per-pool free/active heads, walk cursor, result register
  mpfla_dpath #(
    .NUM_POOLS   (NUM_POOLS),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
